/* hw/rtl/psbd_pkg.sv */
// psbd_pkg: shared types and constants of the per-source burst detector
// used by the interfaces, controller, datapath and top level
package psbd_pkg;

  localparam int KEY_W    = 32;
  localparam int TIME_W   = 32;
  localparam int GAP_W    = 16;
  localparam int COUNT_W  = 8;
  localparam int THRESH_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_DATA_W-1:0] WINDOW_RESET = 16'd2;
  localparam logic [THRESH_W-1:0]   THRESH_RESET = 8'd5;
  localparam logic [COUNT_W-1:0]    COUNT_MAX    = 8'hFF;

  localparam logic [31:0] HASH_MULT = 32'h045D_9F3B;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW    = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  last_time;
    logic [GAP_W-1:0]   gap_sum;
    logic [COUNT_W-1:0] run_count;
    logic               flagged;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic lookup;
    logic probe_next;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic key_hit;
    logic slot_empty;
    logic probe_last;
    logic clear_last;
  } dp_status_t;

endpackage

/* hw/rtl/psbd_if.sv */
// psbd request and result channels, valid/ready handshake
// depends on psbd_pkg for field widths
interface psbd_req_if;
  logic                          valid;
  logic                          ready;
  logic [psbd_pkg::KEY_W-1:0]    source_address;
  logic [psbd_pkg::TIME_W-1:0]   timestamp;

  modport source (output valid, output source_address, output timestamp, input ready);
  modport sink   (input valid, input source_address, input timestamp, output ready);
endinterface

interface psbd_res_if;
  logic                          valid;
  logic                          ready;
  logic                          alert;
  logic                          source_flagged;
  logic [psbd_pkg::COUNT_W-1:0]  visit_count;
  logic                          new_source;
  logic                          table_full;

  modport source (output valid, output alert, output source_flagged, output visit_count,
                  output new_source, output table_full, input ready);
  modport sink   (input valid, input alert, input source_flagged, input visit_count,
                  input new_source, input table_full, output ready);
endinterface

/* hw/rtl/psbd_ram.sv */
// psbd_ram: generic single write port ram with registered read
// no dependencies
module psbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/psbd_ctrl.sv */
// psbd_ctrl: sequencer for clear sweep, hash, probe and commit
// depends on psbd_pkg for command and status structs
module psbd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output logic                   res_valid,
  input  logic                   res_ready,
  input  psbd_pkg::dp_status_t   status,
  output psbd_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CHECK
  } state_t;

  state_t state;
  logic   out_free;
  logic   resolved;

  assign out_free  = !res_valid || res_ready;
  assign resolved  = status.key_hit || status.slot_empty || status.probe_last;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.clear_step = (state == ST_CLEAR);
    cmd.capture    = (state == ST_IDLE) && req_valid;
    cmd.lookup     = (state == ST_HASH);
    cmd.finish     = (state == ST_CHECK) && resolved && out_free;
    cmd.probe_next = (state == ST_CHECK) && !resolved;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      res_valid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (status.clear_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (cmd.finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/psbd_dp.sv */
// psbd_dp: source table ram, hashed probe, run update and result register
// depends on psbd_pkg and psbd_ram
module psbd_dp #(
  parameter int FLOWS = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [psbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psbd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [psbd_pkg::KEY_W-1:0]         in_key,
  input  logic [psbd_pkg::TIME_W-1:0]        in_time,
  input  psbd_pkg::ctrl_cmd_t                cmd,
  output psbd_pkg::dp_status_t               status,
  output logic                               alert,
  output logic                               source_flagged,
  output logic [psbd_pkg::COUNT_W-1:0]       visit_count,
  output logic                               new_source,
  output logic                               table_full
);

  localparam int IDX_W = $clog2(FLOWS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOWS - 1);
  localparam logic [IDX_W:0]   FLOWS_EXT = (IDX_W + 1)'(FLOWS);

  logic [psbd_pkg::KEY_W-1:0]    key_q;
  logic [psbd_pkg::TIME_W-1:0]   time_q;
  logic [31:0]                   prod_q;
  logic [31:0]                   prod_next;
  logic [IDX_W-1:0]              idx_q;
  logic [IDX_W-1:0]              idx_inc;
  logic [IDX_W-1:0]              probes_q;
  logic [IDX_W:0]                hash_raw;
  logic [IDX_W-1:0]              hash_idx;
  logic [psbd_pkg::CFG_DATA_W-1:0] window_q;
  logic [psbd_pkg::THRESH_W-1:0] thresh_q;

  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic                          wr_en;
  logic [psbd_pkg::ENTRY_W-1:0]  wr_bits;
  logic [psbd_pkg::ENTRY_W-1:0]  rd_bits;
  psbd_pkg::entry_t              rd_entry;
  psbd_pkg::entry_t              upd_entry;

  logic [psbd_pkg::TIME_W-1:0]   gap;
  logic [psbd_pkg::TIME_W:0]     gap_total;
  logic                          restart;
  logic [psbd_pkg::COUNT_W-1:0]  count_upd;
  logic [psbd_pkg::COUNT_W-1:0]  base_count;
  logic                          base_flag;
  logic                          reach;
  logic                          store;

  assign prod_next = (in_key ^ {16'h0000, in_key[31:16]}) * psbd_pkg::HASH_MULT;
  assign hash_raw  = {1'b0, prod_q[31 -: IDX_W]};
  assign hash_idx  = (hash_raw >= FLOWS_EXT) ? IDX_W'(hash_raw - FLOWS_EXT)
                                             : hash_raw[IDX_W-1:0];
  assign idx_inc   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

  assign rd_en   = cmd.lookup || cmd.probe_next;
  assign rd_addr = cmd.lookup ? hash_idx : idx_inc;
  assign rd_entry = psbd_pkg::entry_t'(rd_bits);

  assign status.key_hit    = rd_entry.valid && (rd_entry.key == key_q);
  assign status.slot_empty = !rd_entry.valid;
  assign status.probe_last = (probes_q == LAST_IDX);
  assign status.clear_last = (idx_q == LAST_IDX);

  // run update for a hit, fresh run for a new entry
  always_comb begin
    gap        = (time_q >= rd_entry.last_time) ? time_q - rd_entry.last_time : '0;
    gap_total  = {1'b0, gap} + (psbd_pkg::TIME_W + 1)'(rd_entry.gap_sum);
    restart    = gap_total > (psbd_pkg::TIME_W + 1)'(window_q);
    if (restart) begin
      count_upd = psbd_pkg::COUNT_W'(1);
    end else if (rd_entry.run_count == psbd_pkg::COUNT_MAX) begin
      count_upd = psbd_pkg::COUNT_MAX;
    end else begin
      count_upd = rd_entry.run_count + 1'b1;
    end
    base_count = status.slot_empty ? psbd_pkg::COUNT_W'(1) : count_upd;
    base_flag  = status.slot_empty ? 1'b0 : rd_entry.flagged;
    reach      = (base_count == thresh_q) && !base_flag;

    upd_entry.valid     = 1'b1;
    upd_entry.key       = key_q;
    upd_entry.last_time = time_q;
    upd_entry.gap_sum   = (status.slot_empty || restart) ? '0
                                                         : gap_total[psbd_pkg::GAP_W-1:0];
    upd_entry.run_count = base_count;
    upd_entry.flagged   = base_flag || reach;
  end

  assign store   = status.key_hit || status.slot_empty;
  assign wr_en   = cmd.clear_step || (cmd.finish && store);
  assign wr_bits = cmd.clear_step ? '0 : psbd_pkg::ENTRY_W'(upd_entry);

  psbd_ram #(
    .WIDTH (psbd_pkg::ENTRY_W),
    .DEPTH (FLOWS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_q),
    .wr_data (wr_bits),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_q    <= '0;
      probes_q <= '0;
      window_q <= psbd_pkg::WINDOW_RESET;
      thresh_q <= psbd_pkg::THRESH_RESET;
    end else begin
      if (cmd.clear_step || cmd.probe_next) begin
        idx_q <= idx_inc;
      end else if (cmd.lookup) begin
        idx_q <= hash_idx;
      end
      if (cmd.lookup) begin
        probes_q <= '0;
      end else if (cmd.probe_next) begin
        probes_q <= probes_q + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          psbd_pkg::REG_WINDOW:    window_q <= cfg_data;
          psbd_pkg::REG_THRESHOLD: thresh_q <= cfg_data[psbd_pkg::THRESH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_q  <= in_key;
      time_q <= in_time;
      prod_q <= prod_next;
    end
    if (cmd.finish) begin
      alert          <= store && reach;
      source_flagged <= store && upd_entry.flagged;
      visit_count    <= store ? base_count : '0;
      new_source     <= !status.key_hit;
      table_full     <= !store;
    end
  end

endmodule

/* hw/rtl/per_source_burst_detector.sv */
// per_source_burst_detector: hashed source table with per-source burst runs
// steps: accept, table read, then check and write back; each extra probe on a collision adds a table read
// a new request is taken only after the previous one has finished its check and write back
// a full table miss probes all FLOWS slots; a result not taken holds the next check
// reset: synchronous; sweeps all FLOWS slots to clear valid marks, no request taken meanwhile
// depends on psbd_pkg, psbd_if, psbd_ram, psbd_ctrl, psbd_dp
module per_source_burst_detector #(
  parameter int FLOWS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [psbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  psbd_req_if.sink                         req,
  psbd_res_if.source                       res
);

  psbd_pkg::ctrl_cmd_t  cmd;
  psbd_pkg::dp_status_t status;

  psbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  psbd_dp #(
    .FLOWS (FLOWS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_key         (req.source_address),
    .in_time        (req.timestamp),
    .cmd            (cmd),
    .status         (status),
    .alert          (res.alert),
    .source_flagged (res.source_flagged),
    .visit_count    (res.visit_count),
    .new_source     (res.new_source),
    .table_full     (res.table_full)
  );

  a_clear_blocks: assert property (@(posedge clk) rst |=> !req.ready)
    else $error("request taken during clearing");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.table_full |-> res.new_source && !res.alert && !res.source_flagged
      && (res.visit_count == '0))
    else $error("bad table full result");

  a_alert_flags: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.alert |-> res.source_flagged && (res.visit_count != '0))
    else $error("alert without flag");

  a_finish_order: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> $past(cmd.lookup || cmd.probe_next || (cmd.finish == 1'b0)))
    else $error("finish without table read");

endmodule
